[sv/utf32_to_utf8_encoder_core_macros.svh]
// assertion macros for the utf-8 encoder core
`ifndef UTF32_TO_UTF8_ENCODER_CORE_MACROS_SVH
`define UTF32_TO_UTF8_ENCODER_CORE_MACROS_SVH

`ifndef SYNTH
// same-cycle implication
`define U8ENC_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("u8enc assertion failed");
// next-cycle implication
`define U8ENC_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("u8enc assertion failed");
`else
`define U8ENC_ASSERT_IMP(label, clk, rst, ante, cons)
`define U8ENC_ASSERT_NXT(label, clk, rst, ante, cons)
`endif

`endif

[sv/u8enc_pkg.sv]
// shared types and constants of the utf-8 encoder core
package u8enc_pkg;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [15:0] CAPACITY_RESET = 16'hFFFF;

   // encoded length, zero marks an error entry
   localparam logic [2:0] LEN_ERR = 3'd0;
   localparam logic [2:0] LEN_1   = 3'd1;
   localparam logic [2:0] LEN_2   = 3'd2;
   localparam logic [2:0] LEN_3   = 3'd3;
   localparam logic [2:0] LEN_4   = 3'd4;

   localparam logic [7:0] LEAD_2 = 8'hC0;
   localparam logic [7:0] LEAD_3 = 8'hE0;
   localparam logic [7:0] LEAD_4 = 8'hF0;
   localparam logic [7:0] CONT   = 8'h80;

   // one classified request as it travels from front to back
   typedef struct packed {
      logic [3:0][7:0] bytes;  // bytes[0] goes out first
      logic [2:0]      len;
      logic [15:0]     base;   // byte count before this request
   } entry_type;

endpackage

[sv/utf32_to_utf8_encoder_core.sv]
// top level of the utf-32 to utf-8 encoder core
// Streams code points in and utf-8 bytes out, one result per byte (one result
// for a failed request). Each request is classified on acceptance: its 1 to 4
// byte encoding is formed and the running byte count of the string is checked
// against the capacity register, so a request that would overflow, or a code
// point above 0x10FFFF, yields a single error result and every later request
// of the string yields an error too, until a request with tlast set closes the
// string and clears the count. Surrogates are encoded as plain three-byte
// values. Classified requests wait in a two-entry queue; the back end emits
// one byte per cycle into a result register while the receiver takes its
// results, so a request of n bytes gives n results (one for an error), up to
// four per request. Requests are taken every cycle while the queue has room,
// and a request reaches the result channel through the queue, the current
// entry register and the result register. The capacity register resets to
// 65535 and a new value applies from the next request on.
module utf32_to_utf8_encoder_core import u8enc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   // capacity register write port
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] code_point
   input  logic        req_tlast,   // end_of_string
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [7:0] out_byte, [23:8] bytes_written
   output logic [1:0]  rsp_tuser,   // [0] byte_valid, [1] conversion_error
   output logic        rsp_tlast    // last_of_run
);

   // front to queue
   logic      push;
   entry_type push_entry;
   logic      queue_full;

   // queue to back
   logic      head_valid;
   entry_type head_entry;
   logic      pop;

   // unpacked result fields
   logic [7:0]  out_byte;
   logic        byte_valid;
   logic        conversion_error;
   logic [15:0] bytes_written;

   // classification, capacity check and per-string state
   u8enc_front u_front (
      .clock         (clock),
      .reset         (reset),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .req_valid     (req_tvalid),
      .code_point    (req_tdata),
      .end_of_string (req_tlast),
      .queue_full    (queue_full),
      .req_ready     (req_tready),
      .push          (push),
      .push_entry    (push_entry)
   );

   // decouples acceptance from byte emission
   u8enc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .full       (queue_full),
      .head_valid (head_valid),
      .head_entry (head_entry)
   );

   // byte serializer with the result register
   u8enc_back u_back (
      .clock            (clock),
      .reset            (reset),
      .head_valid       (head_valid),
      .head_entry       (head_entry),
      .pop              (pop),
      .rsp_ready        (rsp_tready),
      .rsp_valid        (rsp_tvalid),
      .out_byte         (out_byte),
      .byte_valid       (byte_valid),
      .last_of_run      (rsp_tlast),
      .conversion_error (conversion_error),
      .bytes_written    (bytes_written)
   );

   // pack result fields, lowest field first
   assign rsp_tdata = {bytes_written, out_byte};
   assign rsp_tuser = {conversion_error, byte_valid};

endmodule

[sv/u8enc_front.sv]
// front end: capacity register, classification and per-string state
module u8enc_front import u8enc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data,
   input  logic        req_valid,
   input  logic [31:0] code_point,
   input  logic        end_of_string,
   input  logic        queue_full,
   output logic        req_ready,
   output logic        push,
   output entry_type   push_entry
);

   logic [15:0] capacity_ff, capacity_in;
   logic [15:0] count_ff, count_in;
   logic        stopped_ff, stopped_in;
   logic [2:0]  enc_len;
   logic [3:0][7:0] enc_bytes;
   logic [17:0] need;
   logic        fits;
   logic [2:0]  final_len;

   assign req_ready = !queue_full;
   assign push      = req_valid && req_ready;

   always_comb begin
      enc_bytes = '0;
      enc_len   = LEN_ERR;
      if (code_point[31:7] == '0) begin
         enc_len      = LEN_1;
         enc_bytes[0] = {1'b0, code_point[6:0]};
      end else if (code_point[31:11] == '0) begin
         enc_len      = LEN_2;
         enc_bytes[0] = LEAD_2 | {3'b0, code_point[10:6]};
         enc_bytes[1] = CONT | {2'b0, code_point[5:0]};
      end else if (code_point[31:16] == '0) begin
         enc_len      = LEN_3;
         enc_bytes[0] = LEAD_3 | {4'b0, code_point[15:12]};
         enc_bytes[1] = CONT | {2'b0, code_point[11:6]};
         enc_bytes[2] = CONT | {2'b0, code_point[5:0]};
      end else if (code_point[31:21] == '0 && code_point[20:16] <= 5'h10) begin
         enc_len      = LEN_4;
         enc_bytes[0] = LEAD_4 | {5'b0, code_point[20:18]};
         enc_bytes[1] = CONT | {2'b0, code_point[17:12]};
         enc_bytes[2] = CONT | {2'b0, code_point[11:6]};
         enc_bytes[3] = CONT | {2'b0, code_point[5:0]};
      end
   end

   // whole sequence has to fit into the remaining capacity
   assign need      = {2'b0, count_ff} + {15'b0, enc_len};
   assign fits      = need <= {2'b0, capacity_ff};
   assign final_len = (stopped_ff || !fits) ? LEN_ERR : enc_len;

   assign push_entry.bytes = enc_bytes;
   assign push_entry.len   = final_len;
   assign push_entry.base  = count_ff;

   always_comb begin
      capacity_in = csr_wr_en ? csr_wr_data : capacity_ff;
      count_in    = count_ff;
      stopped_in  = stopped_ff;
      if (push) begin
         if (end_of_string) begin
            count_in   = '0;
            stopped_in = 1'b0;
         end else if (final_len == LEN_ERR) begin
            stopped_in = 1'b1;
         end else begin
            count_in = need[15:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CAPACITY_RESET;
         count_ff    <= '0;
         stopped_ff  <= 1'b0;
      end else begin
         capacity_ff <= capacity_in;
         count_ff    <= count_in;
         stopped_ff  <= stopped_in;
      end
   end

endmodule

[sv/u8enc_queue.sv]
// short fifo of classified requests between front and back
module u8enc_queue import u8enc_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type push_entry,
   input  logic      pop,
   output logic      full,
   output logic      head_valid,
   output entry_type head_entry
);

   entry_type         slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;

   assign full       = count_ff == QCNT_W'(QUEUE_DEPTH);
   assign head_valid = count_ff != '0;
   assign head_entry = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

[sv/u8enc_back.sv]
// back end: walks one entry byte by byte into the result register
`include "utf32_to_utf8_encoder_core_macros.svh"
module u8enc_back import u8enc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        head_valid,
   input  entry_type   head_entry,
   output logic        pop,
   input  logic        rsp_ready,
   output logic        rsp_valid,
   output logic [7:0]  out_byte,
   output logic        byte_valid,
   output logic        last_of_run,
   output logic        conversion_error,
   output logic [15:0] bytes_written
);

   entry_type   cur_ff, cur_in;
   logic        cur_valid_ff, cur_valid_in;
   logic [1:0]  idx_ff, idx_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [7:0]  byte_ff, byte_in;
   logic        bvalid_ff, bvalid_in;
   logic        last_ff, last_in;
   logic        err_ff, err_in;
   logic [15:0] written_ff, written_in;
   logic        out_free;
   logic        issue;
   logic        cur_err;
   logic        cur_last;
   logic [2:0]  idx_next;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign issue    = out_free && cur_valid_ff;
   assign cur_err  = cur_ff.len == LEN_ERR;
   assign idx_next = {1'b0, idx_ff} + 3'd1;
   assign cur_last = cur_err || (idx_next == cur_ff.len);
   assign pop      = head_valid && (!cur_valid_ff || (issue && cur_last));

   always_comb begin
      cur_in       = cur_ff;
      cur_valid_in = cur_valid_ff;
      idx_in       = idx_ff;
      if (pop) begin
         cur_in       = head_entry;
         cur_valid_in = 1'b1;
         idx_in       = '0;
      end else if (issue) begin
         if (cur_last) begin
            // park the index at zero while no entry is held
            cur_valid_in = 1'b0;
            idx_in       = '0;
         end else begin
            idx_in = idx_ff + 1'b1;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      byte_in      = byte_ff;
      bvalid_in    = bvalid_ff;
      last_in      = last_ff;
      err_in       = err_ff;
      written_in   = written_ff;
      if (issue) begin
         rsp_valid_in = 1'b1;
         byte_in      = cur_err ? 8'h00 : cur_ff.bytes[idx_ff];
         bvalid_in    = !cur_err;
         last_in      = cur_last;
         err_in       = cur_err;
         written_in   = cur_err ? cur_ff.base : cur_ff.base + {14'b0, idx_ff} + 16'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         idx_ff       <= '0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         idx_ff       <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff     <= cur_in;
      byte_ff    <= byte_in;
      bvalid_ff  <= bvalid_in;
      last_ff    <= last_in;
      err_ff     <= err_in;
      written_ff <= written_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign out_byte         = byte_ff;
   assign byte_valid       = bvalid_ff;
   assign last_of_run      = last_ff;
   assign conversion_error = err_ff;
   assign bytes_written    = written_ff;

   // an error stands alone and ends its request
   `U8ENC_ASSERT_IMP(a_err_is_last, clock, reset, rsp_valid_ff && err_ff, last_ff && !bvalid_ff)
   // byte index never walks past the encoded length
   `U8ENC_ASSERT_IMP(a_idx_in_range, clock, reset, cur_valid_ff && !cur_err, idx_next <= cur_ff.len)
   // a blocked result register freezes the walk
   `U8ENC_ASSERT_NXT(a_stall_holds, clock, reset, rsp_valid_ff && !rsp_ready, $stable(idx_ff))
   // no new entry taken while the current one still has bytes to go
   `U8ENC_ASSERT_IMP(a_pop_at_end, clock, reset, pop && cur_valid_ff, issue && cur_last)

endmodule

[tb/utf32_to_utf8_encoder_core_tb.sv]
// self-checking testbench of the utf-32 to utf-8 encoder core
module utf32_to_utf8_encoder_core_tb import u8enc_pkg::*; ();

   // one result as seen on the result channel
   typedef struct packed {
      logic [7:0]  out_byte;
      logic        byte_valid;
      logic        last_of_run;
      logic        conversion_error;
      logic [15:0] bytes_written;
   } utf8_result_type;

   // one directed request, with an optional capacity write ahead of it and an
   // optional typed-in result for rows that give exactly one result
   typedef struct packed {
      logic        wr;
      logic [15:0] cap;
      logic [31:0] cp;
      logic        eos;
      logic        known;
      logic [7:0]  out_byte;
      logic        byte_valid;
      logic        conversion_error;
      logic [15:0] bytes_written;
   } stim_row_type;

   localparam int NUM_ROWS     = 24;
   localparam int NUM_PHASES   = 9;
   localparam int PHASE_ITEMS  = 42;
   localparam int DRAIN_CYCLES = 24;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_wr_en = 1'b0;
   logic [15:0] csr_wr_data = '0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        rsp_tlast;

   // predictor state: mirrors the capacity register and the string bookkeeping
   logic [15:0]     capacity = CAPACITY_RESET;
   logic [15:0]     str_byte_count = '0;
   logic            str_stopped = 1'b0;
   utf8_result_type expected_results[$];
   bit              failed = 1'b0;

   // receiver stall pattern
   logic [15:0] ready_pattern = 16'hFFFF;
   logic [15:0] stall_tick = '0;

   stim_row_type directed_rows [NUM_ROWS] = '{
      // capacity at reset: every length class and both ends of each
      '{1'b0, 16'd0,     32'h0000_0000, 1'b0, 1'b1, 8'h00, 1'b1, 1'b0, 16'd1},
      '{1'b0, 16'd0,     32'h0000_007F, 1'b0, 1'b1, 8'h7F, 1'b1, 1'b0, 16'd2},
      '{1'b0, 16'd0,     32'h0000_0080, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 16'd0},
      '{1'b0, 16'd0,     32'h0000_07FF, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 16'd0},
      '{1'b0, 16'd0,     32'h0000_0800, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 16'd0},
      // surrogates go out as plain three-byte values
      '{1'b0, 16'd0,     32'h0000_D800, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 16'd0},
      '{1'b0, 16'd0,     32'h0000_DFFF, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 16'd0},
      '{1'b0, 16'd0,     32'h0000_FFFF, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 16'd0},
      '{1'b0, 16'd0,     32'h0001_0000, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 16'd0},
      '{1'b0, 16'd0,     32'h0010_FFFF, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0, 16'd0},
      // above the code space, then errors while stopped until end of string
      '{1'b0, 16'd0,     32'h0011_0000, 1'b0, 1'b1, 8'h00, 1'b0, 1'b1, 16'd0},
      '{1'b0, 16'd0,     32'h0000_0041, 1'b0, 1'b1, 8'h00, 1'b0, 1'b1, 16'd0},
      '{1'b0, 16'd0,     32'hFFFF_FFFF, 1'b1, 1'b1, 8'h00, 1'b0, 1'b1, 16'd0},
      // end of string cleared the stop
      '{1'b0, 16'd0,     32'h0000_0041, 1'b1, 1'b1, 8'h41, 1'b1, 1'b0, 16'd1},
      // small capacity: fill it exactly, then overflow
      '{1'b1, 16'd3,     32'h0000_0041, 1'b0, 1'b1, 8'h41, 1'b1, 1'b0, 16'd1},
      '{1'b0, 16'd0,     32'h0000_0080, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 16'd0},
      '{1'b0, 16'd0,     32'h0000_0042, 1'b0, 1'b1, 8'h00, 1'b0, 1'b1, 16'd3},
      '{1'b0, 16'd0,     32'h0000_0042, 1'b1, 1'b1, 8'h00, 1'b0, 1'b1, 16'd3},
      '{1'b0, 16'd0,     32'h0001_0000, 1'b1, 1'b1, 8'h00, 1'b0, 1'b1, 16'd0},
      // zero capacity fails everything
      '{1'b1, 16'd0,     32'h0000_0000, 1'b1, 1'b1, 8'h00, 1'b0, 1'b1, 16'd0},
      // capacity lowered in the middle of a string
      '{1'b1, 16'd4,     32'h0000_0041, 1'b0, 1'b1, 8'h41, 1'b1, 1'b0, 16'd1},
      '{1'b0, 16'd0,     32'h0000_0041, 1'b0, 1'b1, 8'h41, 1'b1, 1'b0, 16'd2},
      '{1'b1, 16'd2,     32'h0000_0041, 1'b1, 1'b1, 8'h00, 1'b0, 1'b1, 16'd2},
      '{1'b1, 16'hFFFF,  32'h0010_FFFF, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0, 16'd0}
   };

   utf32_to_utf8_encoder_core uut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),    // [31:0] code_point
      .req_tlast   (req_tlast),    // end_of_string
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),    // [7:0] out_byte, [23:8] bytes_written
      .rsp_tuser   (rsp_tuser),    // [0] byte_valid, [1] conversion_error
      .rsp_tlast   (rsp_tlast)     // last_of_run
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // receiver stalls on a pattern redrawn when the low six tick bits are zero;
   // a quarter of the patterns never stall, the rest keep at least one ready slot
   always @(posedge clock) begin
      stall_tick <= stall_tick + 16'd1;
      if (stall_tick[5:0] == 6'd0) begin
         if ($urandom_range(0, 3) == 0)
            ready_pattern <= 16'hFFFF;
         else
            ready_pattern <= 16'($urandom) | (16'h1 << $urandom_range(0, 15));
      end
      rsp_tready <= ready_pattern[stall_tick[3:0]];
   end

   // works out the results of one accepted request and queues them
   function automatic void predict_encoding(input logic [31:0] cp, input logic eos);
      logic [7:0]      enc [4];
      int unsigned     len;
      utf8_result_type r;
      len = 0;
      if (!str_stopped) begin
         if (cp <= 32'h7F) begin
            enc[0] = cp[7:0];
            len = 1;
         end else if (cp <= 32'h7FF) begin
            enc[0] = LEAD_2 | {3'b000, cp[10:6]};
            enc[1] = CONT | {2'b00, cp[5:0]};
            len = 2;
         end else if (cp <= 32'hFFFF) begin
            enc[0] = LEAD_3 | {4'b0000, cp[15:12]};
            enc[1] = CONT | {2'b00, cp[11:6]};
            enc[2] = CONT | {2'b00, cp[5:0]};
            len = 3;
         end else if (cp <= 32'h10FFFF) begin
            enc[0] = LEAD_4 | {5'b00000, cp[20:18]};
            enc[1] = CONT | {2'b00, cp[17:12]};
            enc[2] = CONT | {2'b00, cp[11:6]};
            enc[3] = CONT | {2'b00, cp[5:0]};
            len = 4;
         end
         // the whole sequence has to fit or nothing of it goes out
         if (len != 0 && 32'(str_byte_count) + len > 32'(capacity))
            len = 0;
         if (len == 0)
            str_stopped = 1'b1;
      end
      if (len == 0) begin
         r = '{8'h00, 1'b0, 1'b1, 1'b1, str_byte_count};
         expected_results.push_back(r);
      end else begin
         for (int unsigned i = 0; i < len; i++) begin
            str_byte_count = str_byte_count + 16'd1;
            r = '{enc[i], 1'b1, (i + 1 == len), 1'b0, str_byte_count};
            expected_results.push_back(r);
         end
      end
      if (eos) begin
         str_byte_count = '0;
         str_stopped = 1'b0;
      end
   endfunction

   // presents one request, waits for its handshake and predicts its results;
   // called at a rising edge, returns at the edge that accepted the request
   task automatic send_request(input logic [31:0] cp, input logic eos);
      req_tvalid <= 1'b1;
      req_tdata  <= cp;
      req_tlast  <= eos;
      @(negedge clock);
      while (!req_tready)
         @(negedge clock);
      @(posedge clock);
      predict_encoding(cp, eos);
   endtask

   // holds the sender off until every queued result has come out
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (expected_results.size() != 0)
         @(posedge clock);
   endtask

   // one-cycle write of the capacity register, only while the block is idle
   task automatic write_capacity(input logic [15:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      capacity = value;
   endtask

   // code point mix: all length classes, surrogates, boundaries and junk
   function automatic logic [31:0] random_code_point();
      case ($urandom_range(0, 15))
         0, 1, 2, 3: return $urandom_range(0, 32'h7F);
         4, 5, 6:    return $urandom_range(32'h80, 32'h7FF);
         7, 8, 9:    return $urandom_range(32'h800, 32'hFFFF);
         10:         return $urandom_range(32'hD800, 32'hDFFF);
         11, 12:     return $urandom_range(32'h1_0000, 32'h10_FFFF);
         13: begin
            case ($urandom_range(0, 9))
               0: return 32'h0;
               1: return 32'h7F;
               2: return 32'h80;
               3: return 32'h7FF;
               4: return 32'h800;
               5: return 32'hFFFF;
               6: return 32'h1_0000;
               7: return 32'h10_FFFF;
               8: return 32'h11_0000;
               default: return 32'hFFFF_FFFF;
            endcase
         end
         14:      return $urandom_range(32'h11_0000, 32'hFFFF_FFFF);
         default: return $urandom();
      endcase
   endfunction

   // result checker: every accepted result against the oldest expectation
   always @(posedge clock) begin : result_check
      utf8_result_type got;
      utf8_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = '{rsp_tdata[7:0], rsp_tuser[0], rsp_tlast, rsp_tuser[1], rsp_tdata[23:8]};
         if (expected_results.size() == 0) begin
            $display("%0t: unexpected result byte=%h valid=%b last=%b err=%b count=%0d",
                     $time, got.out_byte, got.byte_valid, got.last_of_run,
                     got.conversion_error, got.bytes_written);
            failed = 1'b1;
         end else begin
            want = expected_results.pop_front();
            if (got.out_byte !== want.out_byte || got.byte_valid !== want.byte_valid ||
                got.last_of_run !== want.last_of_run ||
                got.conversion_error !== want.conversion_error ||
                got.bytes_written !== want.bytes_written) begin
               $display("%0t: mismatch expected byte=%h valid=%b last=%b err=%b count=%0d",
                        $time, want.out_byte, want.byte_valid, want.last_of_run,
                        want.conversion_error, want.bytes_written);
               $display("%0t:          actual   byte=%h valid=%b last=%b err=%b count=%0d",
                        $time, got.out_byte, got.byte_valid, got.last_of_run,
                        got.conversion_error, got.bytes_written);
               failed = 1'b1;
            end
         end
      end
   end

   // main sequence: reset, directed table, random phases, drain
   initial begin : main_sequence
      int              phase_sent;
      int              str_len;
      int              burst_left;
      int              gap;
      bit              use_gaps;
      logic [15:0]     cap_value;
      utf8_result_type typed;

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed table; typed-in rows replace the single predicted result
      for (int row = 0; row < NUM_ROWS; row++) begin
         if (directed_rows[row].wr) begin
            wait_drained();
            write_capacity(directed_rows[row].cap);
         end
         send_request(directed_rows[row].cp, directed_rows[row].eos);
         if (directed_rows[row].known) begin
            typed = '{directed_rows[row].out_byte, directed_rows[row].byte_valid, 1'b1,
                      directed_rows[row].conversion_error, directed_rows[row].bytes_written};
            expected_results[expected_results.size() - 1] = typed;
         end
      end

      // random phases, each under its own capacity; the drain before every
      // write also pauses the sender until all results are out
      burst_left = 0;
      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         wait_drained();
         case (phase % 4)
            0: cap_value = 16'($urandom_range(0, 12));
            1: cap_value = 16'($urandom_range(8, 48));
            2: cap_value = 16'($urandom_range(0, 65535));
            default: cap_value = (phase == 3) ? 16'hFFFF : 16'd1;
         endcase
         write_capacity(cap_value);
         use_gaps = !(phase == 3 || phase == 6);
         phase_sent = 0;
         while (phase_sent < PHASE_ITEMS) begin
            // mostly short strings so that the capacity limit is often hit
            if (cap_value > 16'd48 && $urandom_range(0, 3) == 0)
               str_len = $urandom_range(1, 30);
            else
               str_len = $urandom_range(1, 10);
            for (int k = 0; k < str_len; k++) begin
               if (burst_left == 0) begin
                  burst_left = $urandom_range(1, 20);
                  if (use_gaps) begin
                     gap = $urandom_range(1, 6);
                     req_tvalid <= 1'b0;
                     repeat (gap) @(posedge clock);
                  end
               end
               send_request(random_code_point(), k == str_len - 1);
               burst_left--;
               phase_sent++;
            end
         end
      end

      // let everything out, then watch a little longer for stray results
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (failed)
         $display("TEST FAILED");
      else
         $display("TEST PASSED");
      $finish;
   end

   // watchdog, far above the slowest legal run
   initial begin
      #5_000_000;
      $display("TEST FAILED");
      $finish;
   end

endmodule
